// ===== hdl/isetb_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the interval set table.
package isetb_pkg;
    localparam int MAX_RANGES_DEF = 16;
    localparam int DAY_W          = 22;
    localparam int ACT_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int RCOUNT_W       = 5;

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_PUSH2,
        S_FINAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic ev;
        logic push2;
        logic fin;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic scan_done;
        logic pend_b;
        logic is_add;
    } sts_t;
endpackage

// ===== hdl/isetb_ctrl.sv =====
// Sequencer for the interval set table: scans, evaluates and commits one item.
module isetb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  isetb_pkg::sts_t sts,
    output isetb_pkg::cmd_t cmd,
    output logic           busy
);
    import isetb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.skip)
                    state_next = S_DONE;
                else if (sts.scan_done)
                    state_next = sts.is_add ? S_FINAL : S_DONE;
                else
                    state_next = S_EVAL;
            end
            S_EVAL:  state_next = sts.pend_b ? S_PUSH2 : S_SCAN;
            S_PUSH2: state_next = S_SCAN;
            S_FINAL: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.rd    = (state_reg == S_SCAN) && !sts.skip && !sts.scan_done;
        cmd.ev    = (state_reg == S_EVAL);
        cmd.push2 = (state_reg == S_PUSH2);
        cmd.fin   = (state_reg == S_FINAL);
        cmd.done  = (state_reg == S_DONE);
        busy      = (state_reg != S_IDLE);
    end
endmodule

// ===== hdl/isetb_dp.sv =====
// Datapath for the interval set table: two range banks, merge/split logic and result registers.
module isetb_dp #(
    parameter int MAX_RANGES = isetb_pkg::MAX_RANGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  isetb_pkg::cmd_t                    cmd,
    input  logic [isetb_pkg::ACT_W-1:0]        action,
    input  logic [isetb_pkg::DAY_W-1:0]        from_day,
    input  logic [isetb_pkg::DAY_W-1:0]        to_day,
    output isetb_pkg::sts_t                    sts,
    output logic                               done,
    output logic                               present,
    output logic [isetb_pkg::STATUS_W-1:0]     status,
    output logic [isetb_pkg::RCOUNT_W-1:0]     range_count
);
    import isetb_pkg::*;

    localparam int AW      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int BANK_SZ = 1 << AW;
    localparam int CW      = $clog2(MAX_RANGES + 1);
    localparam int NW      = $clog2(MAX_RANGES + 2);
    localparam int WW      = DAY_W + 1;

    // both banks in one array; bank_reg selects the live one
    logic [DAY_W-1:0] mem_first [2*BANK_SZ];
    logic [DAY_W-1:0] mem_last  [2*BANK_SZ];

    logic             bank_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    k_reg;
    logic [NW-1:0]    n_reg;
    logic [ACT_W-1:0] act_reg;
    logic             bad_reg;
    logic [WW-1:0]    lo_reg, hi_reg;
    logic             placed_reg, hit_reg;
    logic [DAY_W-1:0] rd_f_reg, rd_l_reg;
    logic [DAY_W-1:0] pb_f_reg, pb_l_reg;
    logic             done_reg, present_reg;
    logic [STATUS_W-1:0] status_reg;

    // evaluation of the entry just read
    logic [WW-1:0]    f_w, l_w;
    logic             c1_v, c2_v;
    logic [DAY_W-1:0] c1_f, c1_l, c2_f, c2_l;
    logic             wr_v;
    logic [DAY_W-1:0] wr_f, wr_l;
    logic             merge;
    logic [31:0]      count_x;

    always_comb
    begin
        f_w   = {1'b0, rd_f_reg};
        l_w   = {1'b0, rd_l_reg};
        c1_v  = 1'b0;
        c2_v  = 1'b0;
        c1_f  = rd_f_reg;
        c1_l  = rd_l_reg;
        c2_f  = rd_f_reg;
        c2_l  = rd_l_reg;
        merge = 1'b0;
        if (act_reg == ACT_ADD)
        begin
            if (l_w + 1'b1 < lo_reg)
            begin
                c1_v = 1'b1;
            end
            else if (f_w > hi_reg + 1'b1)
            begin
                c2_v = 1'b1;
                if (!placed_reg)
                begin
                    c1_v = 1'b1;
                    c1_f = lo_reg[DAY_W-1:0];
                    c1_l = hi_reg[DAY_W-1:0];
                end
            end
            else
            begin
                merge = 1'b1;
            end
        end
        else if (act_reg == ACT_REMOVE)
        begin
            if (l_w < lo_reg || f_w > hi_reg)
            begin
                c1_v = 1'b1;
            end
            else
            begin
                if (f_w < lo_reg)
                begin
                    c1_v = 1'b1;
                    c1_l = DAY_W'(lo_reg - 1'b1);
                end
                if (l_w > hi_reg)
                begin
                    c2_v = 1'b1;
                    c2_f = DAY_W'(hi_reg + 1'b1);
                end
            end
        end
        wr_v = 1'b0;
        wr_f = c1_f;
        wr_l = c1_l;
        if (cmd.ev)
        begin
            wr_v = c1_v || c2_v;
            wr_f = c1_v ? c1_f : c2_f;
            wr_l = c1_v ? c1_l : c2_l;
        end
        else if (cmd.push2)
        begin
            wr_v = 1'b1;
            wr_f = pb_f_reg;
            wr_l = pb_l_reg;
        end
        else if (cmd.fin)
        begin
            wr_v = !placed_reg;
            wr_f = lo_reg[DAY_W-1:0];
            wr_l = hi_reg[DAY_W-1:0];
        end
    end

    // build the new table in the idle bank; drop entries past capacity
    always_ff @(posedge clk)
    begin
        if (wr_v && n_reg < NW'(MAX_RANGES))
        begin
            mem_first[{~bank_reg, n_reg[AW-1:0]}] <= wr_f;
            mem_last [{~bank_reg, n_reg[AW-1:0]}] <= wr_l;
        end
        if (cmd.rd)
        begin
            rd_f_reg <= mem_first[{bank_reg, k_reg[AW-1:0]}];
            rd_l_reg <= mem_last [{bank_reg, k_reg[AW-1:0]}];
        end
        if (cmd.ev)
        begin
            pb_f_reg <= c2_f;
            pb_l_reg <= c2_l;
        end
        if (cmd.load)
        begin
            act_reg <= action;
            bad_reg <= (action != ACT_NONE) && (from_day > to_day);
            lo_reg  <= {1'b0, from_day};
            hi_reg  <= {1'b0, to_day};
        end
        else if (cmd.ev && merge)
        begin
            if (f_w < lo_reg) lo_reg <= f_w;
            if (l_w > hi_reg) hi_reg <= l_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            placed_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
            present_reg <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.load)
            begin
                k_reg      <= '0;
                n_reg      <= '0;
                placed_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            if (cmd.rd)
                k_reg <= k_reg + 1'b1;
            // saturate one past capacity: enough to flag a full table
            if (wr_v && n_reg <= NW'(MAX_RANGES))
                n_reg <= n_reg + 1'b1;
            if (cmd.ev && act_reg == ACT_ADD && c2_v)
                placed_reg <= 1'b1;
            if (cmd.ev && act_reg == ACT_QUERY
                && rd_f_reg <= lo_reg[DAY_W-1:0] && hi_reg[DAY_W-1:0] <= rd_l_reg)
                hit_reg <= 1'b1;
            if (cmd.done)
            begin
                present_reg <= 1'b0;
                status_reg  <= ST_OK;
                if (bad_reg)
                    status_reg <= ST_BAD;
                else if (act_reg == ACT_QUERY)
                    present_reg <= hit_reg;
                else if (act_reg == ACT_ADD || act_reg == ACT_REMOVE)
                begin
                    if (n_reg > NW'(MAX_RANGES))
                        status_reg <= ST_FULL;
                    else
                    begin
                        bank_reg  <= ~bank_reg;
                        count_reg <= CW'(n_reg);
                    end
                end
            end
        end
    end

    always_comb
    begin
        sts.skip      = bad_reg || (act_reg == ACT_NONE);
        sts.scan_done = (k_reg == count_reg);
        // the entry under evaluation writes two ranges; the second goes out next cycle
        sts.pend_b    = c1_v && c2_v;
        sts.is_add    = (act_reg == ACT_ADD);
        count_x       = 32'(count_reg);
        done          = done_reg;
        present       = present_reg;
        status        = status_reg;
        range_count   = count_x[RCOUNT_W-1:0];
    end
endmodule

// ===== hdl/interval_set_table.sv =====
// Interval set table top level: sorted disjoint day ranges with add, remove and query.
// Each stored range is read (SCAN) and evaluated (EVAL); the one range that splits or
//   follows the new range adds PUSH2; a last SCAN, FINAL (add only) and DONE finish.
// A new item waits for the last: busy is high until the result strobe on done, which lasts
//   exactly one cycle; the receiver cannot stall it.
// Reset (rst_n, asynchronous, active low) empties the table; range storage is not cleared.
module interval_set_table #(
    parameter int MAX_RANGES = isetb_pkg::MAX_RANGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [isetb_pkg::ACT_W-1:0]     action,
    input  logic [isetb_pkg::DAY_W-1:0]     from_day,
    input  logic [isetb_pkg::DAY_W-1:0]     to_day,
    output logic                            done,
    output logic                            present,
    output logic [isetb_pkg::STATUS_W-1:0]  status,
    output logic [isetb_pkg::RCOUNT_W-1:0]  range_count
);
    import isetb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: one transfer in, scan the live bank, write the rebuilt table, then commit.
    isetb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: ping-pong banks; a commit flips the bank, a full table keeps the old one.
    isetb_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .from_day    (from_day),
        .to_day      (to_day),
        .sts         (sts),
        .done        (done),
        .present     (present),
        .status      (status),
        .range_count (range_count)
    );
endmodule
